>>> rtl/tlssni_pkg.sv
// Shared types, codes and constants of the TLS ClientHello server name extractor.
package tlssni_pkg;

    // Configuration port geometry and register indexes.
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 16;

    localparam logic [CFG_IDX_W-1:0] CFG_MIN_RECORD_BYTES      = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_HANDSHAKE_RECORD_TYPE = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_CLIENT_HELLO_TYPE     = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_SERVER_NAME_EXT_TYPE  = 2'd3;

    // Register values after reset.
    localparam logic [7:0]  RST_MIN_RECORD_BYTES      = 8'd6;
    localparam logic [7:0]  RST_HANDSHAKE_RECORD_TYPE = 8'd22;
    localparam logic [7:0]  RST_CLIENT_HELLO_TYPE     = 8'd1;
    localparam logic [15:0] RST_SERVER_NAME_EXT_TYPE  = 16'd0;

    // Fixed field sizes of the record and handshake headers.
    localparam int REC_REST_BYTES = 4;
    localparam int HS_LEN_BYTES   = 3;
    localparam int VERSION_BYTES  = 2;
    localparam int RANDOM_WORDS   = 8;
    localparam logic [15:0] REC_REST_COUNT = 16'(REC_REST_BYTES);
    localparam logic [15:0] HS_FIXED_COUNT =
        16'(HS_LEN_BYTES + VERSION_BYTES + RANDOM_WORDS * 4);

    // Status codes closing a packet.
    localparam logic [1:0] ST_NAME_FOUND    = 2'd0;
    localparam logic [1:0] ST_NOT_HELLO     = 2'd1;
    localparam logic [1:0] ST_TOO_SHORT     = 2'd2;
    localparam logic [1:0] ST_NO_NAME       = 2'd3;

    // Result queue geometry.
    localparam int QUEUE_DEPTH = 2;
    localparam int QUEUE_PTR_W = $clog2(QUEUE_DEPTH);
    localparam int QUEUE_CNT_W = $clog2(QUEUE_DEPTH + 1);

    // Parser phases, in the order the packet is walked.
    typedef enum logic [4:0] {
        PH_REC_TYPE, PH_REC_REST, PH_HS_TYPE, PH_HS_FIXED, PH_SID_LEN, PH_SID,
        PH_CS_LEN_HI, PH_CS_LEN_LO, PH_CS, PH_CM_LEN, PH_CM,
        PH_EXTS_LEN_HI, PH_EXTS_LEN_LO, PH_EXT_TYPE_HI, PH_EXT_TYPE_LO,
        PH_EXT_LEN_HI, PH_EXT_LEN_LO, PH_EXT_BODY,
        PH_SNL_HI, PH_SNL_LO, PH_SN_TYPE, PH_SN_LEN_HI, PH_SN_LEN_LO,
        PH_SN_FIRST, PH_SN_REST, PH_FINISHED, PH_IGNORE
    } t_phase;

    // One result item as it travels from the parser to the output stage.
    typedef struct packed {
        logic       name_valid;
        logic [7:0] name_byte;
        logic       name_first;
        logic       name_last;
        logic       done_res;
        logic [1:0] status;
    } t_res;

    // Push side of the result queue.
    typedef struct packed {
        logic push;
        t_res res;
    } t_push;

    // Pop side of the result queue.
    typedef struct packed {
        logic not_empty;
        t_res head;
    } t_head;

endpackage

>>> rtl/tlssni_if.sv
// Valid/ready channel interfaces for packet bytes in and result items out.
interface tlssni_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] payload_byte;
    logic       packet_end;

    modport source (output valid, output payload_byte, output packet_end, input ready);
    modport sink   (input valid, input payload_byte, input packet_end, output ready);
endinterface

interface tlssni_out_if;
    logic       valid;
    logic       ready;
    logic       name_valid;
    logic [7:0] name_byte;
    logic       name_first;
    logic       name_last;
    logic       done_res;
    logic [1:0] status;

    modport source (output valid, output name_valid, output name_byte, output name_first,
                    output name_last, output done_res, output status, input ready);
    modport sink   (input valid, input name_valid, input name_byte, input name_first,
                    input name_last, input done_res, input status, output ready);
endinterface

>>> rtl/tlssni_front.sv
// Front part: accepts packet bytes, walks the ClientHello and classifies each item.
module tlssni_front import tlssni_pkg::*; (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    tlssni_in_if.sink             i_in,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    input  logic                  i_full,
    output t_push                 o_push
);

    logic [7:0]  r_min_bytes;
    logic [7:0]  r_rec_type;
    logic [7:0]  r_hello_type;
    logic [15:0] r_sn_type;

    t_phase      r_phase, n_phase;
    logic [15:0] r_byte_count, n_byte_count;
    logic [15:0] r_field_rem, n_field_rem;
    logic [7:0]  r_len_hi, n_len_hi;
    logic [15:0] r_ext_rem, n_ext_rem;
    logic [15:0] r_ext_type, n_ext_type;
    logic [15:0] r_list_rem, n_list_rem;
    logic        r_found, n_found;

    logic        accept;
    logic [7:0]  b;
    logic        pkt_end;
    logic [15:0] field_dec;
    logic [15:0] ext_dec;
    logic [15:0] list_dec;
    logic [15:0] joined;
    logic        name_char;
    logic        too_short;
    t_phase      walk_phase;
    logic        walk_found;

    assign i_in.ready = !i_full;
    assign accept     = i_in.valid && !i_full;
    assign b          = i_in.payload_byte;
    assign pkt_end    = i_in.packet_end;
    assign field_dec  = r_field_rem - 16'd1;
    assign ext_dec    = r_ext_rem - 16'd1;
    assign list_dec   = r_list_rem - 16'd1;
    assign joined     = {r_len_hi, b};

    // Configuration registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_min_bytes  <= RST_MIN_RECORD_BYTES;
            r_rec_type   <= RST_HANDSHAKE_RECORD_TYPE;
            r_hello_type <= RST_CLIENT_HELLO_TYPE;
            r_sn_type    <= RST_SERVER_NAME_EXT_TYPE;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_MIN_RECORD_BYTES:      r_min_bytes  <= i_cfg_data[7:0];
                CFG_HANDSHAKE_RECORD_TYPE: r_rec_type   <= i_cfg_data[7:0];
                CFG_CLIENT_HELLO_TYPE:     r_hello_type <= i_cfg_data[7:0];
                CFG_SERVER_NAME_EXT_TYPE:  r_sn_type    <= i_cfg_data[15:0];
            endcase
        end
    end

    // Next phase and counters for the current byte.
    always_comb begin
        n_phase      = r_phase;
        n_field_rem  = r_field_rem;
        n_len_hi     = r_len_hi;
        n_ext_rem    = r_ext_rem;
        n_ext_type   = r_ext_type;
        n_list_rem   = r_list_rem;
        n_found      = r_found;
        n_byte_count = r_byte_count;
        unique case (r_phase)
            PH_REC_TYPE: begin
                if (b != r_rec_type) begin
                    n_phase = PH_IGNORE;
                end else begin
                    n_field_rem = REC_REST_COUNT;
                    n_phase     = PH_REC_REST;
                end
            end
            PH_REC_REST: begin
                n_field_rem = field_dec;
                if (field_dec == 16'd0) n_phase = PH_HS_TYPE;
            end
            PH_HS_TYPE: begin
                if (b != r_hello_type) begin
                    n_phase = PH_IGNORE;
                end else begin
                    n_field_rem = HS_FIXED_COUNT;
                    n_phase     = PH_HS_FIXED;
                end
            end
            PH_HS_FIXED: begin
                n_field_rem = field_dec;
                if (field_dec == 16'd0) n_phase = PH_SID_LEN;
            end
            PH_SID_LEN: begin
                n_field_rem = {8'd0, b};
                n_phase     = (b != 8'd0) ? PH_SID : PH_CS_LEN_HI;
            end
            PH_SID: begin
                n_field_rem = field_dec;
                if (field_dec == 16'd0) n_phase = PH_CS_LEN_HI;
            end
            PH_CS_LEN_HI: begin
                n_len_hi = b;
                n_phase  = PH_CS_LEN_LO;
            end
            PH_CS_LEN_LO: begin
                n_field_rem = joined;
                n_phase     = (joined != 16'd0) ? PH_CS : PH_CM_LEN;
            end
            PH_CS: begin
                n_field_rem = field_dec;
                if (field_dec == 16'd0) n_phase = PH_CM_LEN;
            end
            PH_CM_LEN: begin
                n_field_rem = {8'd0, b};
                n_phase     = (b != 8'd0) ? PH_CM : PH_EXTS_LEN_HI;
            end
            PH_CM: begin
                n_field_rem = field_dec;
                if (field_dec == 16'd0) n_phase = PH_EXTS_LEN_HI;
            end
            PH_EXTS_LEN_HI: begin
                n_len_hi = b;
                n_phase  = PH_EXTS_LEN_LO;
            end
            PH_EXTS_LEN_LO: begin
                n_ext_rem = joined;
                n_phase   = (joined != 16'd0) ? PH_EXT_TYPE_HI : PH_FINISHED;
            end
            PH_EXT_TYPE_HI: begin
                n_ext_type = {b, 8'd0};
                n_ext_rem  = ext_dec;
                n_phase    = PH_EXT_TYPE_LO;
            end
            PH_EXT_TYPE_LO: begin
                n_ext_type = {r_ext_type[15:8], b};
                n_ext_rem  = ext_dec;
                n_phase    = PH_EXT_LEN_HI;
            end
            PH_EXT_LEN_HI: begin
                n_len_hi  = b;
                n_ext_rem = ext_dec;
                n_phase   = PH_EXT_LEN_LO;
            end
            PH_EXT_LEN_LO: begin
                n_ext_rem = ext_dec;
                if (r_ext_type == r_sn_type) begin
                    n_phase = PH_SNL_HI;
                end else if (joined != 16'd0) begin
                    n_field_rem = joined;
                    n_phase     = PH_EXT_BODY;
                end else begin
                    n_phase = (ext_dec != 16'd0) ? PH_EXT_TYPE_HI : PH_FINISHED;
                end
            end
            PH_EXT_BODY: begin
                n_ext_rem   = ext_dec;
                n_field_rem = field_dec;
                if (field_dec == 16'd0) begin
                    n_phase = (ext_dec != 16'd0) ? PH_EXT_TYPE_HI : PH_FINISHED;
                end
            end
            PH_SNL_HI: begin
                n_len_hi = b;
                n_phase  = PH_SNL_LO;
            end
            PH_SNL_LO: begin
                n_list_rem = joined;
                n_phase    = (joined != 16'd0) ? PH_SN_TYPE : PH_FINISHED;
            end
            PH_SN_TYPE: begin
                n_list_rem = list_dec;
                n_phase    = PH_SN_LEN_HI;
            end
            PH_SN_LEN_HI: begin
                n_list_rem = list_dec;
                n_len_hi   = b;
                n_phase    = PH_SN_LEN_LO;
            end
            PH_SN_LEN_LO: begin
                n_list_rem  = list_dec;
                n_field_rem = joined;
                if (joined != 16'd0) begin
                    n_phase = PH_SN_FIRST;
                end else begin
                    n_phase = (list_dec != 16'd0) ? PH_SN_TYPE : PH_FINISHED;
                end
            end
            PH_SN_FIRST, PH_SN_REST: begin
                n_list_rem  = list_dec;
                n_field_rem = field_dec;
                if (field_dec == 16'd0) begin
                    n_found = 1'b1;
                    n_phase = (list_dec != 16'd0) ? PH_SN_TYPE : PH_FINISHED;
                end else begin
                    n_phase = PH_SN_REST;
                end
            end
            PH_FINISHED, PH_IGNORE: begin
                n_phase = r_phase;
            end
            default: begin
                n_phase = PH_IGNORE;
            end
        endcase

        // Status of the packet is judged on the state after this byte.
        walk_phase = n_phase;
        walk_found = n_found;

        // The final byte returns everything to the start of the next packet.
        if (pkt_end) begin
            n_phase      = PH_REC_TYPE;
            n_byte_count = 16'd0;
            n_field_rem  = 16'd0;
            n_len_hi     = 8'd0;
            n_ext_rem    = 16'd0;
            n_ext_type   = 16'd0;
            n_list_rem   = 16'd0;
            n_found      = 1'b0;
        end else if (r_byte_count != 16'hFFFF) begin
            n_byte_count = r_byte_count + 16'd1;
        end
    end

    // Result item for the current byte.
    always_comb begin
        name_char = (r_phase == PH_SN_FIRST) || (r_phase == PH_SN_REST);
        too_short = ({1'b0, r_byte_count} + 17'd1) < {9'd0, r_min_bytes};

        o_push.push           = accept && (name_char || pkt_end);
        o_push.res.name_valid = name_char;
        o_push.res.name_byte  = name_char ? b : 8'd0;
        o_push.res.name_first = (r_phase == PH_SN_FIRST);
        o_push.res.name_last  = name_char && (field_dec == 16'd0);
        o_push.res.done_res   = pkt_end;
        if (!pkt_end) begin
            o_push.res.status = ST_NAME_FOUND;
        end else if (too_short) begin
            o_push.res.status = ST_TOO_SHORT;
        end else if (walk_phase == PH_IGNORE) begin
            o_push.res.status = ST_NOT_HELLO;
        end else if (walk_found) begin
            o_push.res.status = ST_NAME_FOUND;
        end else begin
            o_push.res.status = ST_NO_NAME;
        end
    end

    // Parser state advances on every accepted item.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase      <= PH_REC_TYPE;
            r_byte_count <= 16'd0;
            r_field_rem  <= 16'd0;
            r_len_hi     <= 8'd0;
            r_ext_rem    <= 16'd0;
            r_ext_type   <= 16'd0;
            r_list_rem   <= 16'd0;
            r_found      <= 1'b0;
        end else if (accept) begin
            r_phase      <= n_phase;
            r_byte_count <= n_byte_count;
            r_field_rem  <= n_field_rem;
            r_len_hi     <= n_len_hi;
            r_ext_rem    <= n_ext_rem;
            r_ext_type   <= n_ext_type;
            r_list_rem   <= n_list_rem;
            r_found      <= n_found;
        end
    end

endmodule

>>> rtl/tlssni_queue.sv
// Short result queue between the parser and the output stage.
module tlssni_queue import tlssni_pkg::*; (
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  t_push i_push,
    input  logic  i_pop,
    output logic  o_full,
    output t_head o_head
);

    t_res                   r_mem [QUEUE_DEPTH];
    logic [QUEUE_PTR_W-1:0] r_wr_ptr;
    logic [QUEUE_PTR_W-1:0] r_rd_ptr;
    logic [QUEUE_CNT_W-1:0] r_count;
    logic                   do_pop;

    assign o_full           = (r_count == QUEUE_CNT_W'(QUEUE_DEPTH));
    assign o_head.not_empty = (r_count != '0);
    assign o_head.head      = r_mem[r_rd_ptr];
    assign do_pop           = i_pop && o_head.not_empty;

    // Storage is written at the tail.
    always_ff @(posedge i_clk) begin
        if (i_push.push) begin
            r_mem[r_wr_ptr] <= i_push.res;
        end
    end

    // Pointers and fill count.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push.push) begin
                r_wr_ptr <= (r_wr_ptr == QUEUE_PTR_W'(QUEUE_DEPTH - 1)) ? '0 :
                            r_wr_ptr + QUEUE_PTR_W'(1);
            end
            if (do_pop) begin
                r_rd_ptr <= (r_rd_ptr == QUEUE_PTR_W'(QUEUE_DEPTH - 1)) ? '0 :
                            r_rd_ptr + QUEUE_PTR_W'(1);
            end
            if (i_push.push && !do_pop) begin
                r_count <= r_count + QUEUE_CNT_W'(1);
            end else if (!i_push.push && do_pop) begin
                r_count <= r_count - QUEUE_CNT_W'(1);
            end
        end
    end

endmodule

>>> rtl/tlssni_back.sv
// Back part: takes result items from the queue and holds them on the output channel.
module tlssni_back import tlssni_pkg::*; (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  t_head         i_head,
    output logic          o_pop,
    tlssni_out_if.source  o_out
);

    logic r_valid;
    t_res r_res;

    // Load a new item when the output register is empty or being taken.
    assign o_pop = i_head.not_empty && (!r_valid || o_out.ready);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_pop) begin
            r_valid <= 1'b1;
        end else if (o_out.ready) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_res <= i_head.head;
        end
    end

    // Output channel.
    assign o_out.valid      = r_valid;
    assign o_out.name_valid = r_res.name_valid;
    assign o_out.name_byte  = r_res.name_byte;
    assign o_out.name_first = r_res.name_first;
    assign o_out.name_last  = r_res.name_last;
    assign o_out.done_res   = r_res.done_res;
    assign o_out.status     = r_res.status;

endmodule

>>> rtl/tls_client_hello_sni_extract.sv
// TLS ClientHello server name extractor, top level.
// Throughput: one packet byte per cycle while the queue is not full; each accepted byte
// updates counters and phase; result items pass the queue, then the output register.
// A two-entry queue and an output register let input keep flowing while an output stalls.
// Reset (synchronous, active low) restores register defaults and the record header phase.
module tls_client_hello_sni_extract import tlssni_pkg::*; (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    tlssni_in_if.sink             i_in,
    tlssni_out_if.source          o_out,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [CFG_DATA_W-1:0] i_cfg_data
);

    t_push push;
    t_head head;
    logic  full;
    logic  pop;

    // Parser and classifier.
    tlssni_front u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in       (i_in),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .i_full     (full),
        .o_push     (push)
    );

    // Result queue.
    tlssni_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_pop   (pop),
        .o_full  (full),
        .o_head  (head)
    );

    // Output stage.
    tlssni_back u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_head  (head),
        .o_pop   (pop),
        .o_out   (o_out)
    );

endmodule

>>> sim/tb_tls_client_hello_sni_extract.sv
// Self-checking testbench of the TLS ClientHello server name extractor.
module tb_tls_client_hello_sni_extract;
    import tlssni_pkg::*;

    localparam int HOLD_CYCLES    = 60;
    localparam int DRAIN_LIMIT    = 2000;
    localparam int SETTLE_CYCLES  = 8;
    localparam int REPORT_LIMIT   = 10;
    localparam int WATCHDOG_DELAY = 3000000;

    logic                  i_clk;
    logic                  i_rst_n;
    logic                  i_cfg_we;
    logic [CFG_IDX_W-1:0]  i_cfg_idx;
    logic [CFG_DATA_W-1:0] i_cfg_data;

    tlssni_in_if  in_ch ();
    tlssni_out_if out_ch ();

    tls_client_hello_sni_extract uut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in       (in_ch),
        .o_out      (out_ch),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data)
    );

    // Local copy of the register file.
    logic [7:0]  cfg_min_len;
    logic [7:0]  cfg_rec_type;
    logic [7:0]  cfg_hello_type;
    logic [15:0] cfg_sni_type;

    // Parser state as the predictor tracks it.
    t_phase      walk_phase;
    logic [15:0] bytes_seen;
    logic [15:0] field_left;
    logic [15:0] ext_left;
    logic [15:0] ext_type;
    logic [15:0] names_left;
    logic [7:0]  len_hi;
    logic        name_done;

    // Result items still to come, oldest first.
    t_res results_due[$];

    // Packet under construction.
    logic [7:0] pkt[$];

    // Idling and hold-off controls shared between the processes.
    int tx_gap_max;
    int rx_stall_max;
    bit hold_req;
    int holds_done;

    // Run statistics.
    int fail_count;
    int bytes_sent;
    int packets_sent;
    int name_bytes_seen;
    int closes_seen[4];

    // Clock.
    initial i_clk = 1'b0;
    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // Watchdog on the whole run.
    initial begin
        #(WATCHDOG_DELAY);
        $display("CHECK FAILED");
        $finish;
    end

    // Returns the parser to the start of a packet.
    task automatic clear_walk();
        walk_phase = PH_REC_TYPE;
        bytes_seen = '0;
        field_left = '0;
        ext_left   = '0;
        ext_type   = '0;
        names_left = '0;
        len_hi     = '0;
        name_done  = 1'b0;
    endtask

    // Advances the parser by one accepted byte and queues the result it causes.
    task automatic walk_hello_byte(input logic [7:0] b, input logic last);
        logic        nv;
        logic        nf;
        logic        nl;
        logic [16:0] total;
        t_res        r;
        nv = 1'b0;
        nf = 1'b0;
        nl = 1'b0;
        case (walk_phase)
            PH_REC_TYPE: begin
                if (b != cfg_rec_type) walk_phase = PH_IGNORE;
                else begin
                    field_left = REC_REST_COUNT;
                    walk_phase = PH_REC_REST;
                end
            end
            PH_REC_REST: begin
                field_left = field_left - 16'd1;
                if (field_left == 0) walk_phase = PH_HS_TYPE;
            end
            PH_HS_TYPE: begin
                if (b != cfg_hello_type) walk_phase = PH_IGNORE;
                else begin
                    field_left = HS_FIXED_COUNT;
                    walk_phase = PH_HS_FIXED;
                end
            end
            PH_HS_FIXED: begin
                field_left = field_left - 16'd1;
                if (field_left == 0) walk_phase = PH_SID_LEN;
            end
            PH_SID_LEN: begin
                field_left = {8'h00, b};
                walk_phase = (b != 0) ? PH_SID : PH_CS_LEN_HI;
            end
            PH_SID: begin
                field_left = field_left - 16'd1;
                if (field_left == 0) walk_phase = PH_CS_LEN_HI;
            end
            PH_CS_LEN_HI: begin
                len_hi = b;
                walk_phase = PH_CS_LEN_LO;
            end
            PH_CS_LEN_LO: begin
                field_left = {len_hi, b};
                walk_phase = (field_left != 0) ? PH_CS : PH_CM_LEN;
            end
            PH_CS: begin
                field_left = field_left - 16'd1;
                if (field_left == 0) walk_phase = PH_CM_LEN;
            end
            PH_CM_LEN: begin
                field_left = {8'h00, b};
                walk_phase = (b != 0) ? PH_CM : PH_EXTS_LEN_HI;
            end
            PH_CM: begin
                field_left = field_left - 16'd1;
                if (field_left == 0) walk_phase = PH_EXTS_LEN_HI;
            end
            PH_EXTS_LEN_HI: begin
                len_hi = b;
                walk_phase = PH_EXTS_LEN_LO;
            end
            PH_EXTS_LEN_LO: begin
                ext_left = {len_hi, b};
                walk_phase = (ext_left != 0) ? PH_EXT_TYPE_HI : PH_FINISHED;
            end
            PH_EXT_TYPE_HI: begin
                ext_type = {b, 8'h00};
                ext_left = ext_left - 16'd1;
                walk_phase = PH_EXT_TYPE_LO;
            end
            PH_EXT_TYPE_LO: begin
                ext_type[7:0] = b;
                ext_left = ext_left - 16'd1;
                walk_phase = PH_EXT_LEN_HI;
            end
            PH_EXT_LEN_HI: begin
                len_hi = b;
                ext_left = ext_left - 16'd1;
                walk_phase = PH_EXT_LEN_LO;
            end
            PH_EXT_LEN_LO: begin
                ext_left = ext_left - 16'd1;
                if (ext_type == cfg_sni_type) walk_phase = PH_SNL_HI;
                else if ({len_hi, b} != 0) begin
                    field_left = {len_hi, b};
                    walk_phase = PH_EXT_BODY;
                end else begin
                    walk_phase = (ext_left != 0) ? PH_EXT_TYPE_HI : PH_FINISHED;
                end
            end
            PH_EXT_BODY: begin
                ext_left = ext_left - 16'd1;
                field_left = field_left - 16'd1;
                if (field_left == 0)
                    walk_phase = (ext_left != 0) ? PH_EXT_TYPE_HI : PH_FINISHED;
            end
            PH_SNL_HI: begin
                len_hi = b;
                walk_phase = PH_SNL_LO;
            end
            PH_SNL_LO: begin
                names_left = {len_hi, b};
                walk_phase = (names_left != 0) ? PH_SN_TYPE : PH_FINISHED;
            end
            PH_SN_TYPE: begin
                names_left = names_left - 16'd1;
                walk_phase = PH_SN_LEN_HI;
            end
            PH_SN_LEN_HI: begin
                names_left = names_left - 16'd1;
                len_hi = b;
                walk_phase = PH_SN_LEN_LO;
            end
            PH_SN_LEN_LO: begin
                names_left = names_left - 16'd1;
                field_left = {len_hi, b};
                if (field_left != 0) walk_phase = PH_SN_FIRST;
                else walk_phase = (names_left != 0) ? PH_SN_TYPE : PH_FINISHED;
            end
            PH_SN_FIRST, PH_SN_REST: begin
                names_left = names_left - 16'd1;
                field_left = field_left - 16'd1;
                nv = 1'b1;
                nf = (walk_phase == PH_SN_FIRST);
                nl = (field_left == 0);
                if (nl) begin
                    name_done = 1'b1;
                    walk_phase = (names_left != 0) ? PH_SN_TYPE : PH_FINISHED;
                end else begin
                    walk_phase = PH_SN_REST;
                end
            end
            default: ;
        endcase

        // A byte that is neither a name character nor the packet end gives no item.
        if (!nv && !last) begin
            if (bytes_seen != 16'hFFFF) bytes_seen = bytes_seen + 16'd1;
        end else begin
            r.name_valid = nv;
            r.name_byte  = nv ? b : 8'h00;
            r.name_first = nf;
            r.name_last  = nl;
            r.done_res   = last;
            r.status     = ST_NAME_FOUND;
            if (last) begin
                total = {1'b0, bytes_seen} + 17'd1;
                if (total < {9'd0, cfg_min_len}) r.status = ST_TOO_SHORT;
                else if (walk_phase == PH_IGNORE) r.status = ST_NOT_HELLO;
                else if (name_done) r.status = ST_NAME_FOUND;
                else r.status = ST_NO_NAME;
                clear_walk();
            end else if (bytes_seen != 16'hFFFF) begin
                bytes_seen = bytes_seen + 16'd1;
            end
            results_due.push_back(r);
        end
    endtask

    function automatic string res_text(input t_res r);
        return $sformatf("valid=%0d byte=%02h first=%0d last=%0d done=%0d status=%0d",
                         r.name_valid, r.name_byte, r.name_first, r.name_last,
                         r.done_res, r.status);
    endfunction

    // Compares each accepted result item with the oldest one due.
    always @(posedge i_clk) begin
        t_res got;
        t_res want;
        if (i_rst_n === 1'b1 && out_ch.valid === 1'b1 && out_ch.ready === 1'b1) begin
            got.name_valid = out_ch.name_valid;
            got.name_byte  = out_ch.name_byte;
            got.name_first = out_ch.name_first;
            got.name_last  = out_ch.name_last;
            got.done_res   = out_ch.done_res;
            got.status     = out_ch.status;
            if (got.name_valid === 1'b1) name_bytes_seen++;
            if (got.done_res === 1'b1 && !$isunknown(got.status)) closes_seen[got.status]++;
            if (results_due.size() == 0) begin
                fail_count++;
                if (fail_count <= REPORT_LIMIT)
                    $display("%0t: unexpected item: %s", $time, res_text(got));
            end else begin
                want = results_due.pop_front();
                if (got.name_valid !== want.name_valid || got.name_byte !== want.name_byte ||
                    got.name_first !== want.name_first || got.name_last !== want.name_last ||
                    got.done_res !== want.done_res || got.status !== want.status) begin
                    fail_count++;
                    if (fail_count <= REPORT_LIMIT) begin
                        $display("%0t: mismatch, expected %s", $time, res_text(want));
                        $display("%0t:           actual   %s", $time, res_text(got));
                    end
                end
            end
        end
    end

    // Output side: a random stall before each item, and a long hold-off on request.
    initial begin
        int stall;
        out_ch.ready = 1'b0;
        wait (i_rst_n === 1'b1);
        forever begin
            @(negedge i_clk);
            if (hold_req) begin
                out_ch.ready = 1'b0;
                repeat (HOLD_CYCLES) @(negedge i_clk);
                hold_req = 1'b0;
                holds_done++;
            end
            stall = $urandom_range(0, rx_stall_max);
            if (stall != 0) begin
                out_ch.ready = 1'b0;
                repeat (stall) @(negedge i_clk);
            end
            out_ch.ready = 1'b1;
            do @(posedge i_clk); while (!(out_ch.valid === 1'b1));
        end
    end

    // Offers one byte after a random gap and waits until it is taken.
    task automatic send_byte(input logic [7:0] b, input logic last);
        int gap;
        gap = $urandom_range(0, tx_gap_max);
        @(negedge i_clk);
        if (gap != 0) begin
            in_ch.valid = 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        in_ch.valid        = 1'b1;
        in_ch.payload_byte = b;
        in_ch.packet_end   = last;
        do @(posedge i_clk); while (!(in_ch.ready === 1'b1));
        walk_hello_byte(b, last);
        bytes_sent++;
    endtask

    task automatic send_packet();
        for (int i = 0; i < pkt.size(); i++) send_byte(pkt[i], i == pkt.size() - 1);
        packets_sent++;
    endtask

    // Stops offering and waits until every due item has arrived and the pipe is empty.
    task automatic drain();
        int waited;
        @(negedge i_clk);
        in_ch.valid = 1'b0;
        waited = 0;
        while (results_due.size() != 0 && waited < DRAIN_LIMIT) begin
            @(posedge i_clk);
            waited++;
        end
        if (results_due.size() != 0) begin
            fail_count += results_due.size();
            $display("%0t: %0d expected items never arrived", $time, results_due.size());
            results_due.delete();
        end
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    // Writes one configuration register; only called while the block is idle.
    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [15:0] value);
        @(negedge i_clk);
        i_cfg_we   = 1'b1;
        i_cfg_idx  = idx;
        i_cfg_data = value;
        @(posedge i_clk);
        case (idx)
            CFG_MIN_RECORD_BYTES:      cfg_min_len    = value[7:0];
            CFG_HANDSHAKE_RECORD_TYPE: cfg_rec_type   = value[7:0];
            CFG_CLIENT_HELLO_TYPE:     cfg_hello_type = value[7:0];
            CFG_SERVER_NAME_EXT_TYPE:  cfg_sni_type   = value;
            default: ;
        endcase
        @(negedge i_clk);
        i_cfg_we = 1'b0;
    endtask

    task automatic set_regs(input logic [7:0] min_len, input logic [7:0] rec_type,
                            input logic [7:0] hello_type, input logic [15:0] sni_type);
        write_reg(CFG_MIN_RECORD_BYTES, {8'h00, min_len});
        write_reg(CFG_HANDSHAKE_RECORD_TYPE, {8'h00, rec_type});
        write_reg(CFG_CLIENT_HELLO_TYPE, {8'h00, hello_type});
        write_reg(CFG_SERVER_NAME_EXT_TYPE, sni_type);
    endtask

    // Builds a ClientHello with random content; some are cut, padded or corrupted.
    task automatic build_hello();
        int          sid_len;
        int          cs_len;
        int          cm_len;
        int          n_ext;
        int          sni_at;
        int          n_names;
        int          name_len;
        int          cut;
        logic [15:0] len16;
        logic [15:0] etype;
        logic [7:0]  body[$];
        logic [7:0]  names[$];
        pkt.delete();
        pkt.push_back(($urandom_range(0, 9) != 0) ? cfg_rec_type : 8'($urandom));
        repeat (REC_REST_BYTES) pkt.push_back(8'($urandom));
        pkt.push_back(($urandom_range(0, 9) != 0) ? cfg_hello_type : 8'($urandom));
        repeat (HS_FIXED_COUNT) pkt.push_back(8'($urandom));

        // Session ID, cipher suites and compression methods, empty now and then.
        sid_len = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 32);
        pkt.push_back(8'(sid_len));
        repeat (sid_len) pkt.push_back(8'($urandom));
        cs_len = ($urandom_range(0, 3) == 0) ? 0 : 2 * $urandom_range(1, 4);
        pkt.push_back(8'h00);
        pkt.push_back(8'(cs_len));
        repeat (cs_len) pkt.push_back(8'($urandom));
        cm_len = $urandom_range(0, 2);
        pkt.push_back(8'(cm_len));
        repeat (cm_len) pkt.push_back(8'($urandom));

        // Extension list with the server name extension at a random place, or absent.
        n_ext  = $urandom_range(0, 3);
        sni_at = $urandom_range(0, n_ext);
        for (int e = 0; e < n_ext; e++) begin
            if (e == sni_at) begin
                names.delete();
                n_names = $urandom_range(0, 3);
                for (int k = 0; k < n_names; k++) begin
                    name_len = ($urandom_range(0, 4) == 0) ? 0 : $urandom_range(1, 8);
                    names.push_back(8'($urandom));
                    names.push_back(8'h00);
                    names.push_back(8'(name_len));
                    repeat (name_len) names.push_back(8'($urandom));
                end
                len16 = ($urandom_range(0, 4) == 0) ? 16'($urandom_range(0, names.size() + 2))
                                                    : 16'(names.size());
                body.push_back(cfg_sni_type[15:8]);
                body.push_back(cfg_sni_type[7:0]);
                body.push_back(8'h00);
                body.push_back(8'(names.size() + 2));
                body.push_back(len16[15:8]);
                body.push_back(len16[7:0]);
                foreach (names[k]) body.push_back(names[k]);
            end else begin
                etype = 16'($urandom);
                if (etype == cfg_sni_type) etype = etype ^ 16'h0100;
                name_len = $urandom_range(0, 5);
                body.push_back(etype[15:8]);
                body.push_back(etype[7:0]);
                body.push_back(8'h00);
                body.push_back(8'(name_len));
                repeat (name_len) body.push_back(8'($urandom));
            end
        end
        len16 = ($urandom_range(0, 5) == 0) ? 16'($urandom_range(0, body.size() + 3))
                                            : 16'(body.size());
        pkt.push_back(len16[15:8]);
        pkt.push_back(len16[7:0]);
        foreach (body[k]) pkt.push_back(body[k]);

        // Broken sequences: early end, trailing bytes or one corrupted byte.
        if ($urandom_range(0, 4) == 0) begin
            cut = $urandom_range(1, pkt.size());
            while (pkt.size() > cut) void'(pkt.pop_back());
        end else if ($urandom_range(0, 3) == 0) begin
            repeat ($urandom_range(1, 4)) pkt.push_back(8'($urandom));
        end
        if ($urandom_range(0, 9) == 0) pkt[$urandom_range(0, pkt.size() - 1)] = 8'($urandom);
    endtask

    // Sends the given number of random ClientHellos and waits for their items.
    task automatic run_hellos(input int count);
        repeat (count) begin
            build_hello();
            send_packet();
        end
        drain();
    endtask

    task automatic set_idling(input int tx_max, input int rx_max);
        tx_gap_max   = tx_max;
        rx_stall_max = rx_max;
    endtask

    // Tiny packets: too short, wrong record type, wrong handshake type, cut header.
    task automatic test_short_packets();
        set_idling(3, 3);
        pkt = '{RST_HANDSHAKE_RECORD_TYPE};
        send_packet();
        pkt = '{8'h00, 8'hFF, 8'h00, 8'h00, 8'h00};
        send_packet();
        pkt = '{8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF};
        send_packet();
        pkt = '{RST_HANDSHAKE_RECORD_TYPE, 8'h03, 8'h01, 8'h00, 8'h05, 8'h02};
        send_packet();
        pkt = '{RST_HANDSHAKE_RECORD_TYPE, 8'h03, 8'h01, 8'h00, 8'h05,
                RST_CLIENT_HELLO_TYPE, 8'h00};
        send_packet();
        drain();
    endtask

    // Well-formed and broken ClientHellos at the reset settings, first without idling.
    task automatic test_hello_streams();
        set_idling(0, 0);
        run_hellos(1);
        set_idling(13, 13);
        run_hellos(1);
        set_idling(0, 13);
        run_hellos(1);
        set_idling(13, 0);
        run_hellos(1);
    endtask

    // Register extremes and one random setting.
    task automatic test_register_settings();
        set_idling(13, 13);
        set_regs(8'd1, 8'h00, 8'hFF, 16'hFFFF);
        run_hellos(1);
        set_regs(8'd255, 8'hFF, 8'h00, 16'h0000);
        run_hellos(1);
        set_regs(8'($urandom_range(2, 60)), 8'($urandom), 8'($urandom), 16'($urandom));
        run_hellos(1);
    endtask

    // The output holds off for a long stretch while short packets, each closing
    // with an item, keep coming, so that the block fills and stalls its input.
    task automatic test_output_hold();
        set_regs(RST_MIN_RECORD_BYTES, RST_HANDSHAKE_RECORD_TYPE, RST_CLIENT_HELLO_TYPE,
                 RST_SERVER_NAME_EXT_TYPE);
        set_idling(0, 2);
        hold_req = 1'b1;
        repeat (30) begin
            pkt.delete();
            repeat ($urandom_range(1, 3)) pkt.push_back(8'($urandom));
            send_packet();
        end
        drain();
    endtask

    // Random garbage packets, sometimes starting with the right record type.
    task automatic test_noise_packets();
        int start;
        set_idling(13, 13);
        start = bytes_sent;
        while (bytes_sent - start < 30) begin
            pkt.delete();
            repeat ($urandom_range(1, 24)) pkt.push_back(8'($urandom));
            if ($urandom_range(0, 1) == 0) pkt[0] = cfg_rec_type;
            send_packet();
        end
        drain();
    endtask

    // Main sequence.
    initial begin
        i_rst_n            = 1'b0;
        i_cfg_we           = 1'b0;
        i_cfg_idx          = '0;
        i_cfg_data         = '0;
        in_ch.valid        = 1'b0;
        in_ch.payload_byte = '0;
        in_ch.packet_end   = 1'b0;
        hold_req           = 1'b0;
        holds_done         = 0;
        fail_count         = 0;
        bytes_sent         = 0;
        packets_sent       = 0;
        name_bytes_seen    = 0;
        closes_seen        = '{0, 0, 0, 0};
        set_idling(0, 0);
        cfg_min_len    = RST_MIN_RECORD_BYTES;
        cfg_rec_type   = RST_HANDSHAKE_RECORD_TYPE;
        cfg_hello_type = RST_CLIENT_HELLO_TYPE;
        cfg_sni_type   = RST_SERVER_NAME_EXT_TYPE;
        clear_walk();

        repeat (11) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        test_short_packets();
        test_hello_streams();
        test_register_settings();
        test_output_hold();
        test_noise_packets();

        $display("Run covered %0d bytes in %0d packets, %0d register settings, %0d hold-offs.",
                 bytes_sent, packets_sent, 5, holds_done);
        $display("Name bytes %0d; closes found/not hello/short/no name: %0d/%0d/%0d/%0d.",
                 name_bytes_seen, closes_seen[ST_NAME_FOUND], closes_seen[ST_NOT_HELLO],
                 closes_seen[ST_TOO_SHORT], closes_seen[ST_NO_NAME]);
        if (fail_count == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end

endmodule
